@@ rtl/core/rti_pkg.sv @@
// Shared constants, register codes and control types of the rigid transform index generator.
`default_nettype none

package rti_pkg;

    // Image geometry and lane count
    localparam int IMAGE_DIM = 512;
    localparam int LANES     = 8;

    // Field widths
    localparam int POS_W    = 9;
    localparam int SHIFT_W  = 24;
    localparam int TRIG_W   = 18;
    localparam int SLICE_W  = 9;
    localparam int INDEX_W  = 27;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 24;
    localparam int IN_TDATA_W  = ((2 * POS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LANES * INDEX_W + 7) / 8) * 8;

    // Datapath widths
    localparam int FRAC_W  = 16;
    localparam int COL_W   = POS_W + 1;                 // col_base plus a lane offset
    localparam int MUL_W   = COL_W + TRIG_W;
    localparam int OFF_W   = 34;                        // half image in Q16 minus shift in Q16
    localparam int SUM_W   = OFF_W + 2;
    localparam int CRD_W   = SUM_W - FRAC_W;            // floored coordinate
    localparam int DIM_W   = $clog2(IMAGE_DIM);
    localparam int LIN_W   = $clog2(IMAGE_DIM * IMAGE_DIM);
    localparam int PROD_W  = (LIN_W + SLICE_W > INDEX_W) ? LIN_W + SLICE_W : INDEX_W;
    localparam int IDX_MAX = 67108863;
    localparam longint HALF_Q16 = longint'(IMAGE_DIM / 2) * 65536;

    // Register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_SHIFT_X = 3'd0,
        REG_SHIFT_Y = 3'd1,
        REG_COSINE  = 3'd2,
        REG_SINE    = 3'd3,
        REG_SLICES  = 3'd4
    } rti_reg_t;

    // Transform settings seen by every lane
    typedef struct packed {
        logic signed [TRIG_W-1:0] cosine;
        logic signed [TRIG_W-1:0] sine;
        logic        [SLICE_W-1:0] slices;
        logic signed [OFF_W-1:0]  off_x;
        logic signed [OFF_W-1:0]  off_y;
    } rti_cfg_t;

    // Stage load enables of the lane pipeline
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } rti_pipe_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/rti_cfg_regs.sv @@
// Configuration register file with precomputed centre offsets.
`default_nettype none

module rti_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [rti_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [rti_pkg::CFG_D_W-1:0]   cfg_data,
    output rti_pkg::rti_cfg_t                  cfg
);

    rti_pkg::rti_cfg_t cfg_reg;
    rti_pkg::rti_cfg_t cfg_next;
    logic signed [rti_pkg::OFF_W-1:0] shift_q16;
    logic signed [rti_pkg::OFF_W-1:0] off_new;

    // Scale the Q8 shift to Q16 and subtract it from the image centre
    always_comb
    begin
        shift_q16 = $signed({{(rti_pkg::OFF_W - rti_pkg::SHIFT_W - 8){cfg_data[rti_pkg::SHIFT_W-1]}},
                             cfg_data[rti_pkg::SHIFT_W-1:0], 8'h00});
        off_new   = rti_pkg::OFF_W'(rti_pkg::HALF_Q16) - shift_q16;
    end

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                rti_pkg::REG_SHIFT_X: cfg_next.off_x  = off_new;
                rti_pkg::REG_SHIFT_Y: cfg_next.off_y  = off_new;
                rti_pkg::REG_COSINE:  cfg_next.cosine = cfg_data[rti_pkg::TRIG_W-1:0];
                rti_pkg::REG_SINE:    cfg_next.sine   = cfg_data[rti_pkg::TRIG_W-1:0];
                rti_pkg::REG_SLICES:  cfg_next.slices = cfg_data[rti_pkg::SLICE_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_x  <= rti_pkg::OFF_W'(rti_pkg::HALF_Q16);
            cfg_reg.off_y  <= rti_pkg::OFF_W'(rti_pkg::HALF_Q16);
            cfg_reg.cosine <= rti_pkg::TRIG_W'(65536);
            cfg_reg.sine   <= '0;
            cfg_reg.slices <= rti_pkg::SLICE_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/rti_lane.sv @@
// One lane: rotate, translate, floor, bound check and scale to a source index.
`default_nettype none

module rti_lane (
    input  wire logic                               clk,
    input  wire rti_pkg::rti_pipe_ctl_t             ctl,
    input  wire rti_pkg::rti_cfg_t                  cfg,
    input  wire logic signed [rti_pkg::POS_W-1:0]   row_pos,
    input  wire logic signed [rti_pkg::COL_W-1:0]   col,
    output logic [rti_pkg::INDEX_W-1:0]             index
);

    // Stage 1: products
    logic signed [rti_pkg::MUL_W-1:0] ccs_reg, csn_reg;
    logic signed [rti_pkg::MUL_W-1:0] rsn_reg, rcs_reg;
    // Stage 2: linear address and bound flag
    logic signed [rti_pkg::SUM_W-1:0] sum_x, sum_y;
    logic signed [rti_pkg::CRD_W-1:0] crd_x, crd_y;
    logic                             inb_next, inb_reg;
    logic [rti_pkg::LIN_W-1:0]        lin_next, lin_reg;
    // Stage 3: scaled index
    logic [rti_pkg::PROD_W-1:0]       prod;
    logic [rti_pkg::INDEX_W-1:0]      index_next, index_reg;

    // Multiply column and row by cosine and sine
    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            ccs_reg <= rti_pkg::MUL_W'(col * cfg.cosine);
            csn_reg <= rti_pkg::MUL_W'(col * cfg.sine);
            rsn_reg <= rti_pkg::MUL_W'(row_pos * cfg.sine);
            rcs_reg <= rti_pkg::MUL_W'(row_pos * cfg.cosine);
        end
    end

    // Sum, floor by dropping fraction bits, check bounds, form the linear address
    always_comb
    begin
        sum_x = rti_pkg::SUM_W'(ccs_reg) - rti_pkg::SUM_W'(rsn_reg) + rti_pkg::SUM_W'(cfg.off_x);
        sum_y = rti_pkg::SUM_W'(csn_reg) + rti_pkg::SUM_W'(rcs_reg) + rti_pkg::SUM_W'(cfg.off_y);
        crd_x = sum_x[rti_pkg::SUM_W-1:rti_pkg::FRAC_W];
        crd_y = sum_y[rti_pkg::SUM_W-1:rti_pkg::FRAC_W];
        inb_next = !crd_x[rti_pkg::CRD_W-1] && !crd_y[rti_pkg::CRD_W-1]
                   && (crd_x < rti_pkg::CRD_W'(rti_pkg::IMAGE_DIM))
                   && (crd_y < rti_pkg::CRD_W'(rti_pkg::IMAGE_DIM));
        lin_next = rti_pkg::LIN_W'(crd_y[rti_pkg::DIM_W-1:0]) * rti_pkg::LIN_W'(rti_pkg::IMAGE_DIM)
                   + rti_pkg::LIN_W'(crd_x[rti_pkg::DIM_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            inb_reg <= inb_next;
            lin_reg <= lin_next;
        end
    end

    // Scale by the slice count, saturate, mark out-of-bounds lanes
    always_comb
    begin
        prod = rti_pkg::PROD_W'(lin_reg) * rti_pkg::PROD_W'(cfg.slices);
        if (!inb_reg)
            index_next = '1;
        else if (prod > rti_pkg::PROD_W'(rti_pkg::IDX_MAX))
            index_next = rti_pkg::INDEX_W'(rti_pkg::IDX_MAX);
        else
            index_next = prod[rti_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            index_reg <= index_next;
        end
    end

    assign index = index_reg;

endmodule

`default_nettype wire

@@ rtl/core/rti_merge.sv @@
// Merge stage: pack lane indices into one output word and hold it for the consumer.
`default_nettype none

module rti_merge (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              lanes_valid,
    input  wire logic [rti_pkg::INDEX_W-1:0]       lane_index [rti_pkg::LANES],
    output logic                                   load_ready,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [rti_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    logic                               valid_reg;
    logic [rti_pkg::OUT_TDATA_W-1:0]    data_reg, data_next;

    // Accept new lane results whenever the output word is empty or leaving
    assign load_ready = !valid_reg || m_axis_tready;

    // Concatenate lanes, lane 0 lowest
    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < rti_pkg::LANES; i++)
        begin
            data_next[i*rti_pkg::INDEX_W +: rti_pkg::INDEX_W] = lane_index[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= lanes_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && lanes_valid)
            data_reg <= data_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/rigid_transform_index_gen_core.sv @@
// Top level of the rigid transform index generator: config, lanes, merge and flow control.
`default_nettype none

// Takes one word per cycle when not stalled (centred row and lane-0 column) and returns one
// word of eight source indices, one per adjacent column, after rotation by the configured
// cosine and sine and translation by the configured shift. A lane that falls outside the
// image gives all ones. Throughput is one word per clock while the output is not stalled.
// An accepted word passes four registers: the three lane stages (products, sum/floor/bounds,
// slice scaling) and the merge output register, which holds it with m_axis_tvalid high
// until it is taken. Bubbles in the pipeline let new words in while a result waits.
// Configuration writes are always taken and must only happen while the block is idle.
module rigid_transform_index_gen_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rti_pkg::CFG_A_W-1:0]       cfg_addr,
    input  wire logic [rti_pkg::CFG_D_W-1:0]       cfg_data,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rti_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // row_pos, col_base, pad
    // Output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [rti_pkg::OUT_TDATA_W-1:0]        m_axis_tdata    // index_0 .. index_7
);

    rti_pkg::rti_cfg_t      cfg;
    rti_pkg::rti_pipe_ctl_t ctl;
    logic                   v1_reg, v2_reg, v3_reg;
    logic                   load_ready;
    logic                   in_fire;
    logic signed [rti_pkg::POS_W-1:0] row_pos, col_base;
    logic signed [rti_pkg::COL_W-1:0] col [rti_pkg::LANES];
    logic [rti_pkg::INDEX_W-1:0]      lane_index [rti_pkg::LANES];

    assign cfg_ready = 1'b1;

    rti_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input word
    assign row_pos  = s_axis_tdata[rti_pkg::POS_W-1:0];
    assign col_base = s_axis_tdata[2*rti_pkg::POS_W-1:rti_pkg::POS_W];

    // Advance each stage when the one after it is empty or moving
    always_comb
    begin
        ctl.en3 = !v3_reg || load_ready;
        ctl.en2 = !v2_reg || ctl.en3;
        ctl.en1 = !v1_reg || ctl.en2;
    end

    assign s_axis_tready = ctl.en1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ctl.en1)
                v1_reg <= in_fire;
            if (ctl.en2)
                v2_reg <= v1_reg;
            if (ctl.en3)
                v3_reg <= v2_reg;
        end
    end

    // Lanes, each on its own column
    for (genvar g = 0; g < rti_pkg::LANES; g++)
    begin : g_lane
        assign col[g] = rti_pkg::COL_W'(col_base) + rti_pkg::COL_W'(g);

        rti_lane u_lane (
            .clk     (clk),
            .ctl     (ctl),
            .cfg     (cfg),
            .row_pos (row_pos),
            .col     (col[g]),
            .index   (lane_index[g])
        );
    end

    rti_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .lanes_valid   (v3_reg),
        .lane_index    (lane_index),
        .load_ready    (load_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A full, stalled pipeline must refuse input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && v1_reg && v2_reg && v3_reg) |-> !s_axis_tready)
        else $error("input accepted while pipeline full and stalled");

    // An accepted word occupies the first stage next cycle
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> v1_reg)
        else $error("accepted word lost at first stage");

    // Lane 0 is either out of bounds or within the saturated index range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[rti_pkg::INDEX_W-1] ||
                           (&m_axis_tdata[rti_pkg::INDEX_W-1:0])))
        else $error("lane 0 index outside its range");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the rigid transform index generator core.
`timescale 1ns / 1ps

// Predicts the eight lane indices of every accepted word and checks the output stream
class lane_index_board;
    localparam int DIM = rti_pkg::IMAGE_DIM;
    localparam int IW  = rti_pkg::INDEX_W;

    logic signed [rti_pkg::SHIFT_W-1:0] shift_x;
    logic signed [rti_pkg::SHIFT_W-1:0] shift_y;
    logic signed [rti_pkg::TRIG_W-1:0]  cosine;
    logic signed [rti_pkg::TRIG_W-1:0]  sine;
    logic        [rti_pkg::SLICE_W-1:0] slices;
    logic [rti_pkg::OUT_TDATA_W-1:0]    expected_words[$];
    int                                 bad_count;

    function new();
        shift_x   = '0;
        shift_y   = '0;
        cosine    = 18'sd65536;
        sine      = '0;
        slices    = 9'd1;
        bad_count = 0;
    endfunction

    // Mirror a register write
    function void set_reg(logic [rti_pkg::CFG_A_W-1:0] code, logic [rti_pkg::CFG_D_W-1:0] data);
        case (code)
            rti_pkg::REG_SHIFT_X: shift_x = data;
            rti_pkg::REG_SHIFT_Y: shift_y = data;
            rti_pkg::REG_COSINE:  cosine  = data[rti_pkg::TRIG_W-1:0];
            rti_pkg::REG_SINE:    sine    = data[rti_pkg::TRIG_W-1:0];
            rti_pkg::REG_SLICES:  slices  = data[rti_pkg::SLICE_W-1:0];
            default: ;
        endcase
    endfunction

    // Rotate and translate each lane's column, floor, bound-check and scale
    function void note_row(logic [rti_pkg::IN_TDATA_W-1:0] d);
        logic signed [rti_pkg::POS_W-1:0] row;
        logic signed [rti_pkg::POS_W-1:0] col;
        longint r;
        longint cb;
        longint c;
        longint off_x;
        longint off_y;
        longint x;
        longint y;
        longint idx;
        logic [rti_pkg::OUT_TDATA_W-1:0] word;
        int lane;
        row   = d[8:0];
        col   = d[17:9];
        r     = row;
        cb    = col;
        off_x = longint'(DIM / 2) * 65536 - longint'(shift_x) * 256;
        off_y = longint'(DIM / 2) * 65536 - longint'(shift_y) * 256;
        word  = '0;
        for (lane = 0; lane < rti_pkg::LANES; lane++)
        begin
            c = cb + lane;
            x = (c * longint'(cosine) - r * longint'(sine) + off_x) >>> 16;
            y = (c * longint'(sine) + r * longint'(cosine) + off_y) >>> 16;
            if (x < 0 || y < 0 || x >= DIM || y >= DIM)
            begin
                word[lane*IW +: IW] = '1;
            end
            else
            begin
                idx = (y * DIM + x) * longint'(slices);
                if (idx > rti_pkg::IDX_MAX)
                    idx = rti_pkg::IDX_MAX;
                word[lane*IW +: IW] = idx[IW-1:0];
            end
        end
        expected_words.push_back(word);
    endfunction

    // Compare an output word lane by lane with the oldest prediction
    function void check_word(logic [rti_pkg::OUT_TDATA_W-1:0] got);
        logic [rti_pkg::OUT_TDATA_W-1:0] want;
        logic [IW-1:0] a;
        logic [IW-1:0] b;
        int lane;
        if (expected_words.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("unexpected index word %h", got);
            return;
        end
        want = expected_words.pop_front();
        for (lane = 0; lane < rti_pkg::LANES; lane++)
        begin
            a = want[lane*IW +: IW];
            b = got[lane*IW +: IW];
            if (a !== b)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("lane %0d mismatch: expected %0d, got %0d",
                             lane, $signed(a), $signed(b));
            end
        end
    endfunction
endclass

module tb;
    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [rti_pkg::CFG_A_W-1:0]        cfg_addr;
    logic [rti_pkg::CFG_D_W-1:0]        cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [rti_pkg::IN_TDATA_W-1:0]     s_axis_tdata;   // row_pos, col_base, pad
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [rti_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;   // index_0 .. index_7

    lane_index_board board;
    bit              send_steady;
    bit              take_steady;

    rigid_transform_index_gen_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the stream hangs
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Observe handshakes: check outputs first, then note new words and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                board.note_row(s_axis_tdata);
            if (cfg_valid && cfg_ready)
                board.set_reg(cfg_addr, cfg_data);
        end
    end

    // Stall the output side for a random gap before each word, unless take_steady is set
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            gap = take_steady ? 0 : $urandom_range(0, 11);
            repeat (gap)
            begin
                @(negedge clk);
                m_axis_tready = 1'b0;
            end
            @(negedge clk);
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(int row, int col);
        int gap;
        logic [rti_pkg::POS_W-1:0] row_bits;
        logic [rti_pkg::POS_W-1:0] col_bits;
        row_bits = row[8:0];
        col_bits = col[8:0];
        gap = send_steady ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(rti_pkg::IN_TDATA_W - 2 * rti_pkg::POS_W){1'b0}}, col_bits, row_bits};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every predicted word has come out
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (board.expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(rti_pkg::rti_reg_t code, int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_addr  = code;
        cfg_data  = value[23:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(int sx, int sy, int cs, int sn, int sl);
        wait_drained();
        write_reg(rti_pkg::REG_SHIFT_X, sx);
        write_reg(rti_pkg::REG_SHIFT_Y, sy);
        write_reg(rti_pkg::REG_COSINE, cs);
        write_reg(rti_pkg::REG_SINE, sn);
        write_reg(rti_pkg::REG_SLICES, sl);
    endtask

    // Pick a transform: mostly trig terms within +-1.0 and shifts within +-256 pixels
    task automatic random_setting();
        int kind;
        int cs;
        int sn;
        int sx;
        int sy;
        int sl;
        kind = $urandom_range(0, 5);
        cs = int'($urandom_range(0, 131072)) - 65536;
        sn = int'($urandom_range(0, 131072)) - 65536;
        sx = int'($urandom_range(0, 131072)) - 65536;
        sy = int'($urandom_range(0, 131072)) - 65536;
        sl = $urandom_range(1, 256);
        case (kind)
            0:
            begin
                cs = 65536;
                sn = 0;
            end
            1: sl = $urandom_range(257, 511);
            2:
            begin
                sx = $urandom;
                sy = $urandom;
                cs = $urandom;
                sn = $urandom;
                sl = $urandom_range(0, 511);
            end
            3: sl = 0;
            default: ;
        endcase
        apply_setting(sx, sy, cs, sn, sl);
    endtask

    // Random words with idle patterns changing every twenty words and one full drain
    task automatic run_phase(int count);
        int drain_at;
        int k;
        int row;
        int col;
        drain_at = $urandom_range(1, count - 1);
        for (k = 0; k < count; k++)
        begin
            if (k % 20 == 0)
            begin
                send_steady = ($urandom_range(0, 3) == 0);
                take_steady = ($urandom_range(0, 3) == 0);
            end
            if (k == drain_at)
                wait_drained();
            row = $urandom;
            col = $urandom;
            if ($urandom_range(0, 2) == 0)
            begin
                row = int'($urandom_range(0, 255)) - 128;
                col = int'($urandom_range(0, 255)) - 128;
            end
            send_word(row, col);
        end
    endtask

    initial
    begin
        int p;
        board         = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_steady   = 1'b0;
        take_steady   = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset transform: identity, field extremes and the right image edge
        send_word(0, 0);
        send_word(-256, -256);
        send_word(255, 255);
        send_word(-256, 255);
        send_word(255, -256);
        send_word(-1, -8);
        send_word(100, 248);
        send_word(-129, 170);

        // Half-pixel shifts with the largest normal slice count
        apply_setting(128, -128, 65536, 0, 256);
        send_word(0, 0);
        send_word(255, -256);
        send_word(-256, 0);

        // Index too large: saturate
        apply_setting(0, 0, 65536, 0, 511);
        send_word(255, 0);
        send_word(200, -100);

        // Zero slice count
        apply_setting(0, 0, 65536, 0, 0);
        send_word(10, 10);
        send_word(-256, -256);

        // Quarter turn, then extreme trig terms
        apply_setting(0, 0, 0, 65536, 3);
        send_word(5, -3);
        send_word(255, 255);
        apply_setting(0, 0, -65536, 65536, 7);
        send_word(0, 0);
        send_word(-256, 255);

        // Out-of-range registers and full-scale shifts
        apply_setting(8388607, -8388608, -131072, 131071, 1);
        send_word(0, 0);
        send_word(255, -256);
        apply_setting(-8388608, 8388607, 131071, -131072, 1);
        send_word(0, 0);

        // Random phases, each under a fresh transform
        for (p = 0; p < 10; p++)
        begin
            random_setting();
            run_phase(60);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.bad_count == 0 && board.expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/rti_pkg.sv
rtl/core/rti_cfg_regs.sv
rtl/core/rti_lane.sv
rtl/core/rti_merge.sv
rtl/core/rigid_transform_index_gen_core.sv
test/tb.sv
